[rtl/gcn_pkg.sv]
package gcn_pkg;

   localparam int LON_W      = 29;
   localparam int LAT_W      = 28;
   localparam int STEP_W     = 24;
   localparam int COLS_W     = 16;
   localparam int LIM_W      = 21;
   localparam int DIST_W     = 24;
   localparam int IDX_W      = 20;
   localparam int LIMIT_W    = 3;
   localparam int MAX_CELLS  = 5;

   localparam int DIFF_W     = LON_W + 1;
   localparam int MAG_W      = LON_W;
   localparam int PROD_W     = MAG_W + COLS_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = LON_W;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_WEST_EDGE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOUTH_EDGE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LONGITUDE_STEP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LATITUDE_STEP  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_COUNT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_LIMIT     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_NEAR_DISTANCE  = 3'd6;

   localparam logic [STEP_W-1:0] STEP_RESET          = 24'd1;
   localparam logic [COLS_W-1:0] COLUMN_COUNT_RESET  = 16'd1;
   localparam logic [LIM_W-1:0]  CELL_LIMIT_RESET    = 21'd1;
   localparam logic [DIST_W-1:0] NEAR_DISTANCE_RESET = 24'd1000;

   typedef struct packed {
      logic signed [LON_W-1:0] west_edge;
      logic signed [LAT_W-1:0] south_edge;
      logic [STEP_W-1:0]       longitude_step;
      logic [STEP_W-1:0]       latitude_step;
      logic [COLS_W-1:0]       column_count;
      logic [LIM_W-1:0]        cell_limit;
      logic [DIST_W-1:0]       near_distance;
   } gcn_cfg_type;

   typedef struct packed {
      logic [DIFF_W-1:0]  dlon;
      logic [DIFF_W-1:0]  dlat;
      logic [MAG_W-1:0]   mag_lon;
      logic [MAG_W-1:0]   mag_lat;
      logic               near_mode;
      logic [LIMIT_W-1:0] result_limit;
   } gcn_side_type;

   typedef struct packed {
      logic                              valid;
      logic [MAX_CELLS-1:0][IDX_W-1:0]   cells;
      logic [LIMIT_W-1:0]                count;
   } gcn_list_type;

endpackage

[rtl/gcn_div_pipe.sv]
module gcn_div_pipe #(
   parameter int NUM_W  = 29,
   parameter int DEN_W  = 24,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num_a,
   input  logic [DEN_W-1:0]  den_a,
   input  logic [NUM_W-1:0]  num_b,
   input  logic [DEN_W-1:0]  den_b,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [NUM_W-1:0]  quot_a,
   output logic [DEN_W-1:0]  rem_a,
   output logic [NUM_W-1:0]  quot_b,
   output logic [DEN_W-1:0]  rem_b,
   output logic [SIDE_W-1:0] side_out
);

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] nq;
   } lane_type;

   // one restoring step: numerator bits leave at the top, quotient bits enter at the bottom
   function automatic lane_type div_step(lane_type cur, logic [DEN_W-1:0] den);
      logic [DEN_W:0] shifted;
      logic [DEN_W:0] diff;
      logic           ge;
      lane_type       nxt;
      shifted = {cur.rem, cur.nq[NUM_W-1]};
      diff    = shifted - {1'b0, den};
      ge      = shifted >= {1'b0, den};
      nxt.rem = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      nxt.nq  = {cur.nq[NUM_W-2:0], ge};
      return nxt;
   endfunction

   lane_type          a_ff    [NUM_W];
   lane_type          b_ff    [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];
   logic [NUM_W-1:0]  valid_ff;

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      lane_type          a_prev;
      lane_type          b_prev;
      logic [SIDE_W-1:0] s_prev;
      logic              v_prev;

      if (k == 0) begin : g_first
         assign a_prev = '{rem: '0, nq: num_a};
         assign b_prev = '{rem: '0, nq: num_b};
         assign s_prev = side_in;
         assign v_prev = in_valid;
      end else begin : g_next
         assign a_prev = a_ff[k-1];
         assign b_prev = b_ff[k-1];
         assign s_prev = side_ff[k-1];
         assign v_prev = valid_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            a_ff[k]    <= div_step(a_prev, den_a);
            b_ff[k]    <= div_step(b_prev, den_b);
            side_ff[k] <= s_prev;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign quot_a    = a_ff[NUM_W-1].nq;
   assign rem_a     = a_ff[NUM_W-1].rem;
   assign quot_b    = b_ff[NUM_W-1].nq;
   assign rem_b     = b_ff[NUM_W-1].rem;
   assign side_out  = side_ff[NUM_W-1];

endmodule

[rtl/gcn_cell_calc.sv]
module gcn_cell_calc (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  gcn_pkg::gcn_cfg_type  cfg,
   input  logic                  in_valid,
   input  logic [gcn_pkg::MAG_W-1:0]  quot_x,
   input  logic [gcn_pkg::STEP_W-1:0] rem_x,
   input  logic [gcn_pkg::MAG_W-1:0]  quot_y,
   input  logic [gcn_pkg::STEP_W-1:0] rem_y,
   input  gcn_pkg::gcn_side_type side,
   output gcn_pkg::gcn_list_type list
);
   import gcn_pkg::*;

   localparam int SUM_W = DIFF_W + 2;

   typedef struct packed {
      logic [MAG_W-1:0]   x;
      logic [MAG_W-1:0]   xs;
      logic [MAG_W-1:0]   ys;
      logic [PROD_W-1:0]  prod;
      logic [DIFF_W-1:0]  dlon;
      logic [DIFF_W-1:0]  dlat;
      logic               near_mode;
      logic [LIMIT_W-1:0] limit;
   } stage_b_type;

   typedef struct packed {
      logic [LIM_W-1:0]   own;
      logic [3:0]         close;
      logic               near_mode;
      logic [LIMIT_W-1:0] limit;
   } stage_c_type;

   stage_b_type  b_in, b_ff;
   stage_c_type  c_in, c_ff;
   gcn_list_type d_in, d_ff;
   logic         b_valid_ff, c_valid_ff;

   // stage b: column/row base offsets and row product
   logic             lon_step_zero, lat_step_zero;
   logic [MAG_W-1:0] y_eff;

   always_comb begin
      lon_step_zero = cfg.longitude_step == '0;
      lat_step_zero = cfg.latitude_step == '0;
      y_eff         = lat_step_zero ? '0 : quot_y;
      b_in.x        = lon_step_zero ? '0 : quot_x;
      b_in.xs       = lon_step_zero ? '0 : side.mag_lon - MAG_W'(rem_x);
      b_in.ys       = lat_step_zero ? '0 : side.mag_lat - MAG_W'(rem_y);
      b_in.prod     = PROD_W'(y_eff) * PROD_W'(cfg.column_count);
      b_in.dlon     = side.dlon;
      b_in.dlat     = side.dlat;
      b_in.near_mode = side.near_mode;
      b_in.limit    = side.result_limit;
   end

   // stage c: own index and edge distances
   logic [PROD_W:0]         sq;
   logic signed [SUM_W-1:0] dlon_s, dlat_s, xs_s, ys_s, lstep_s, tstep_s, nd_s;

   always_comb begin
      sq      = {1'b0, b_ff.prod} + (PROD_W + 1)'(b_ff.x);
      dlon_s  = $signed({{(SUM_W-DIFF_W){b_ff.dlon[DIFF_W-1]}}, b_ff.dlon});
      dlat_s  = $signed({{(SUM_W-DIFF_W){b_ff.dlat[DIFF_W-1]}}, b_ff.dlat});
      xs_s    = $signed(SUM_W'(b_ff.xs));
      ys_s    = $signed(SUM_W'(b_ff.ys));
      lstep_s = $signed(SUM_W'(cfg.longitude_step));
      tstep_s = $signed(SUM_W'(cfg.latitude_step));
      nd_s    = $signed(SUM_W'(cfg.near_distance));
      c_in.own      = (sq >= (PROD_W + 1)'(cfg.cell_limit)) ? '0 : sq[LIM_W-1:0];
      c_in.close[0] = (dlon_s - xs_s) < nd_s;
      c_in.close[1] = (xs_s + lstep_s - dlon_s) < nd_s;
      c_in.close[2] = (dlat_s - ys_s) < nd_s;
      c_in.close[3] = (ys_s + tstep_s - dlat_s) < nd_s;
      c_in.near_mode = b_ff.near_mode;
      c_in.limit     = b_ff.limit;
   end

   // stage d: neighbour checks in west, east, south, north order, capped by the limit
   logic [LIM_W:0]     up_one, up_row;
   logic [3:0][IDX_W-1:0] cand;
   logic [3:0]         cand_ok;
   logic [LIMIT_W-1:0] limit_eff;
   logic [LIMIT_W-1:0] cnt;

   always_comb begin
      up_one     = {1'b0, c_ff.own} + (LIM_W + 1)'(1);
      up_row     = {1'b0, c_ff.own} + (LIM_W + 1)'(cfg.column_count);
      cand[0]    = IDX_W'(c_ff.own - LIM_W'(1));
      cand[1]    = up_one[IDX_W-1:0];
      cand[2]    = IDX_W'(c_ff.own - LIM_W'(cfg.column_count));
      cand[3]    = up_row[IDX_W-1:0];
      cand_ok[0] = c_ff.close[0] && (c_ff.own != '0);
      cand_ok[1] = c_ff.close[1] && (up_one < (LIM_W + 1)'(cfg.cell_limit));
      cand_ok[2] = c_ff.close[2] && (c_ff.own >= LIM_W'(cfg.column_count));
      cand_ok[3] = c_ff.close[3] && (up_row < (LIM_W + 1)'(cfg.cell_limit));
      limit_eff  = (c_ff.limit == '0) ? LIMIT_W'(1) : c_ff.limit;
      d_in.cells    = '0;
      d_in.cells[0] = c_ff.own[IDX_W-1:0];
      cnt           = LIMIT_W'(1);
      for (int i = 0; i < 4; i++) begin
         if (c_ff.near_mode && cand_ok[i] && (cnt < limit_eff)) begin
            d_in.cells[cnt] = cand[i];
            cnt             = cnt + LIMIT_W'(1);
         end
      end
      d_in.count = cnt;
      d_in.valid = c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_ff.valid <= 1'b0;
      end else if (enable) begin
         b_valid_ff <= in_valid;
         c_valid_ff <= b_valid_ff;
         d_ff.valid <= d_in.valid;
      end
      if (enable) begin
         b_ff       <= b_in;
         c_ff       <= c_in;
         d_ff.cells <= d_in.cells;
         d_ff.count <= d_in.count;
      end
   end

   assign list = d_ff;

endmodule

[rtl/gcn_emitter.sv]
module gcn_emitter (
   input  logic                       clock,
   input  logic                       reset,
   input  gcn_pkg::gcn_list_type      list,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [gcn_pkg::IDX_W-1:0]  cell_index,
   output logic                       last_cell,
   output logic                       advance
);
   import gcn_pkg::*;

   logic                            busy_ff;
   logic [LIMIT_W-1:0]              pos_ff;
   logic [LIMIT_W-1:0]              count_ff;
   logic [MAX_CELLS-1:0][IDX_W-1:0] cells_ff;

   assign rsp_tvalid = busy_ff;
   assign cell_index = cells_ff[pos_ff];
   assign last_cell  = pos_ff == (count_ff - LIMIT_W'(1));
   // take the next list once the current one is empty or its last item leaves
   assign advance    = !busy_ff || (rsp_tready && last_cell);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else if (advance) begin
         busy_ff <= list.valid;
         pos_ff  <= '0;
      end else if (rsp_tready) begin
         pos_ff  <= pos_ff + LIMIT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cells_ff <= list.cells;
         count_ff <= list.count;
      end
   end

endmodule

[rtl/grid_cell_and_near_neighbours_unit.sv]
// Grid cell lookup with optional near-edge neighbours.
// req_ channel: one item per map position. tdata from bit 0 up: longitude (29, signed),
//   latitude (28, signed), near_mode (1), result_limit (3), zero pad.
// rsp_ channel: one item per cell index, own cell first, then west, east, south, north
//   neighbours that lie within near_distance; tlast marks the final index of a position.
// csr_ port: csr_we writes csr_wdata to register csr_index (0 west_edge .. 6 near_distance).
//   Write only while no position is in flight.
// Path: a position is registered in stage 1, then passes the two 29-step restoring dividers,
//   the b, c and d registers of the cell calculation and the emitter register to rsp_tvalid.
// Throughput: one position per cycle while each yields one index and rsp_tready stays
//   high; a position with several indices holds the output until its last index is taken,
//   and the pipeline accepts no new position meanwhile; at most five indices per position.
// Reset clears the registers to their defaults and empties the pipeline.
// While the output stage is busy and its last index is not taken, the whole pipeline holds;
//   req_tready drops once the output stage cannot take the next position, and nothing is lost or repeated.
module grid_cell_and_near_neighbours_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gcn_pkg::REQ_DATA_W-1:0]    req_tdata,   // longitude, latitude, near_mode, result_limit
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gcn_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // cell_index
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [gcn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gcn_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gcn_pkg::*;

   localparam int LAT_LSB   = LON_W;
   localparam int NEAR_BIT  = LON_W + LAT_W;
   localparam int LIMIT_LSB = NEAR_BIT + 1;

   gcn_cfg_type  cfg_ff, cfg_in;
   gcn_side_type s1_ff, s1_in;
   logic         s1_valid_ff;
   logic         advance;

   always_comb begin
      cfg_in = cfg_ff;
      case (csr_index)
         REG_WEST_EDGE:      cfg_in.west_edge      = csr_wdata[LON_W-1:0];
         REG_SOUTH_EDGE:     cfg_in.south_edge     = csr_wdata[LAT_W-1:0];
         REG_LONGITUDE_STEP: cfg_in.longitude_step = csr_wdata[STEP_W-1:0];
         REG_LATITUDE_STEP:  cfg_in.latitude_step  = csr_wdata[STEP_W-1:0];
         REG_COLUMN_COUNT:   cfg_in.column_count   = csr_wdata[COLS_W-1:0];
         REG_CELL_LIMIT:     cfg_in.cell_limit     = csr_wdata[LIM_W-1:0];
         REG_NEAR_DISTANCE:  cfg_in.near_distance  = csr_wdata[DIST_W-1:0];
         default:            cfg_in                = cfg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.west_edge      <= '0;
         cfg_ff.south_edge     <= '0;
         cfg_ff.longitude_step <= STEP_RESET;
         cfg_ff.latitude_step  <= STEP_RESET;
         cfg_ff.column_count   <= COLUMN_COUNT_RESET;
         cfg_ff.cell_limit     <= CELL_LIMIT_RESET;
         cfg_ff.near_distance  <= NEAR_DISTANCE_RESET;
      end else if (csr_we) begin
         cfg_ff <= cfg_in;
      end
   end

   // stage 1: offsets from the west/south edges and their magnitudes
   logic [LON_W-1:0]  lon;
   logic [LAT_W-1:0]  lat;
   logic [DIFF_W-1:0] dlon, dlat, abs_lon, abs_lat;

   always_comb begin
      lon     = req_tdata[LON_W-1:0];
      lat     = req_tdata[LAT_LSB +: LAT_W];
      dlon    = {lon[LON_W-1], lon} - {cfg_ff.west_edge[LON_W-1], cfg_ff.west_edge};
      dlat    = {{(DIFF_W-LAT_W){lat[LAT_W-1]}}, lat}
              - {{(DIFF_W-LAT_W){cfg_ff.south_edge[LAT_W-1]}}, cfg_ff.south_edge};
      abs_lon = dlon[DIFF_W-1] ? (~dlon + DIFF_W'(1)) : dlon;
      abs_lat = dlat[DIFF_W-1] ? (~dlat + DIFF_W'(1)) : dlat;
      s1_in.dlon         = dlon;
      s1_in.dlat         = dlat;
      s1_in.mag_lon      = abs_lon[MAG_W-1:0];
      s1_in.mag_lat      = abs_lat[MAG_W-1:0];
      s1_in.near_mode    = req_tdata[NEAR_BIT];
      s1_in.result_limit = req_tdata[LIMIT_LSB +: LIMIT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
      end
   end

   logic              div_valid;
   logic [MAG_W-1:0]  quot_x, quot_y;
   logic [STEP_W-1:0] rem_x, rem_y;
   gcn_side_type      div_side;

   gcn_div_pipe #(
      .NUM_W  (MAG_W),
      .DEN_W  (STEP_W),
      .SIDE_W ($bits(gcn_side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (s1_valid_ff),
      .num_a     (s1_ff.mag_lon),
      .den_a     (cfg_ff.longitude_step),
      .num_b     (s1_ff.mag_lat),
      .den_b     (cfg_ff.latitude_step),
      .side_in   (s1_ff),
      .out_valid (div_valid),
      .quot_a    (quot_x),
      .rem_a     (rem_x),
      .quot_b    (quot_y),
      .rem_b     (rem_y),
      .side_out  (div_side)
   );

   gcn_list_type list;

   gcn_cell_calc u_calc (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .cfg      (cfg_ff),
      .in_valid (div_valid),
      .quot_x   (quot_x),
      .rem_x    (rem_x),
      .quot_y   (quot_y),
      .rem_y    (rem_y),
      .side     (div_side),
      .list     (list)
   );

   logic [IDX_W-1:0] cell_index;

   gcn_emitter u_emit (
      .clock      (clock),
      .reset      (reset),
      .list       (list),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cell_index (cell_index),
      .last_cell  (rsp_tlast),
      .advance    (advance)
   );

   assign req_tready = advance;
   assign rsp_tdata  = RSP_DATA_W'(cell_index);

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output stage is empty");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted item did not enter the pipeline");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((LIM_W'(cell_index) < cfg_ff.cell_limit) || (cell_index == '0)))
      else $error("emitted cell index outside the grid");

endmodule
